// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the deframer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define FMCD_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included
`define FMCD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/fmcd_pkg.sv -----
// Types, constants and decode helpers of the framed motion command decoder
package fmcd_pkg;

    // Frame geometry
    localparam int PAYLOAD_BYTES = 6;
    localparam int CNT_W         = $clog2(PAYLOAD_BYTES);
    localparam int REPLY_BYTES   = 5;
    localparam int REPLY_W       = 8 * REPLY_BYTES;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration registers
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL   = 1'b1;
    localparam logic [7:0] HEADER_RESET = 8'hFF;
    localparam logic [7:0] TAIL_RESET   = 8'hFE;

    // Command codes carried in payload byte 0
    localparam logic [7:0] OP_Y_FWD     = 8'h07;
    localparam logic [7:0] OP_Y_BACK    = 8'h08;
    localparam logic [7:0] OP_X_BACK    = 8'h09;
    localparam logic [7:0] OP_Y_FWD_ALT = 8'hA9;
    localparam logic [7:0] OP_MOVE_POS  = 8'h0B;
    localparam logic [7:0] OP_MOVE_NEG  = 8'h0C;
    localparam logic [7:0] OP_TILT      = 8'h0D;
    localparam logic [7:0] TILT_ARG_OFF = 8'h00;
    localparam logic [7:0] TILT_ARG_ON  = 8'h01;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_BODY = 2'd1,
        PH_TAIL = 2'd2
    } t_phase;

    // Command classes handed from front to back
    typedef enum logic [2:0] {
        CMD_NONE     = 3'd0,
        CMD_Y_POS    = 3'd1,
        CMD_Y_NEG    = 3'd2,
        CMD_X_NEG    = 3'd3,
        CMD_MOVE_POS = 3'd4,
        CMD_MOVE_NEG = 3'd5,
        CMD_TILT_OFF = 3'd6,
        CMD_TILT_ON  = 3'd7
    } t_cmd;

    // One classified item
    typedef struct packed {
        logic               ok;
        t_cmd               cmd;
        logic [7:0]         b1;
        logic [7:0]         b2;
        logic [7:0]         b3;
        logic [REPLY_W-1:0] reply;
    } t_job;

    // Map command byte and first argument to a command class
    function automatic t_cmd classify(input logic [7:0] op, input logic [7:0] arg);
        t_cmd c;
        c = CMD_NONE;
        case (op)
            OP_Y_FWD, OP_Y_FWD_ALT: c = CMD_Y_POS;
            OP_Y_BACK:              c = CMD_Y_NEG;
            OP_X_BACK:              c = CMD_X_NEG;
            OP_MOVE_POS:            c = CMD_MOVE_POS;
            OP_MOVE_NEG:            c = CMD_MOVE_NEG;
            OP_TILT: begin
                if (arg == TILT_ARG_OFF) begin
                    c = CMD_TILT_OFF;
                end else if (arg == TILT_ARG_ON) begin
                    c = CMD_TILT_ON;
                end
            end
            default:                c = CMD_NONE;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/core/fmcd_front.sv -----
// Front end: frame tracking, payload capture and command classification
module fmcd_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic [7:0]                      i_rx_byte,
    input  logic                            i_cfg_we,
    input  logic [fmcd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [7:0]                      i_cfg_wdata,
    output fmcd_pkg::t_job                  o_job
);

    localparam logic [fmcd_pkg::CNT_W-1:0] LAST_IDX =
        fmcd_pkg::CNT_W'(fmcd_pkg::PAYLOAD_BYTES - 1);

    fmcd_pkg::t_phase             r_phase, n_phase;
    logic [fmcd_pkg::CNT_W-1:0]   r_count, n_count;
    logic [7:0]                   r_header;
    logic [7:0]                   r_tail;
    logic [7:0]                   r_pay [fmcd_pkg::PAYLOAD_BYTES];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= fmcd_pkg::HEADER_RESET;
            r_tail   <= fmcd_pkg::TAIL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fmcd_pkg::CFG_HEADER: r_header <= i_cfg_wdata;
                fmcd_pkg::CFG_TAIL:   r_tail   <= i_cfg_wdata;
                default:              ;
            endcase
        end
    end

    // Phase and byte counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= fmcd_pkg::PH_HUNT;
            r_count <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    // Capture payload bytes
    always_ff @(posedge i_clk) begin
        if (i_accept && r_phase == fmcd_pkg::PH_BODY) begin
            r_pay[r_count] <= i_rx_byte;
        end
    end

    // Next phase and classified item
    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        o_job.ok    = 1'b0;
        o_job.cmd   = fmcd_pkg::CMD_NONE;
        o_job.b1    = r_pay[1];
        o_job.b2    = r_pay[2];
        o_job.b3    = r_pay[3];
        o_job.reply = {r_pay[5], r_pay[4], r_pay[3], r_pay[2], r_pay[1]};
        case (r_phase)
            fmcd_pkg::PH_BODY: begin
                if (r_count == LAST_IDX) begin
                    n_phase = fmcd_pkg::PH_TAIL;
                    n_count = '0;
                end else begin
                    n_count = r_count + fmcd_pkg::CNT_W'(1);
                end
            end
            fmcd_pkg::PH_TAIL: begin
                // wrong tail: drop the byte and keep waiting
                if (i_rx_byte == r_tail) begin
                    n_phase   = fmcd_pkg::PH_HUNT;
                    o_job.ok  = 1'b1;
                    o_job.cmd = fmcd_pkg::classify(r_pay[0], r_pay[1]);
                end
            end
            default: begin
                if (i_rx_byte == r_header) begin
                    n_phase = fmcd_pkg::PH_BODY;
                    n_count = '0;
                end
            end
        endcase
    end

endmodule

// ----- rtl/core/fmcd_queue.sv -----
// Short show-ahead queue of classified items between front and back
`include "assert_macros.svh"

module fmcd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  fmcd_pkg::t_job i_data,
    output logic           o_full,
    input  logic           i_rd,
    output fmcd_pkg::t_job o_data,
    output logic           o_empty
);

    localparam logic [fmcd_pkg::QPTR_W-1:0] LAST_SLOT =
        fmcd_pkg::QPTR_W'(fmcd_pkg::QUEUE_DEPTH - 1);
    localparam logic [fmcd_pkg::QCNT_W-1:0] DEPTH_CNT =
        fmcd_pkg::QCNT_W'(fmcd_pkg::QUEUE_DEPTH);

    fmcd_pkg::t_job              r_slot [fmcd_pkg::QUEUE_DEPTH];
    logic [fmcd_pkg::QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [fmcd_pkg::QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [fmcd_pkg::QCNT_W-1:0] r_count, n_count;
    logic                        wr_go;
    logic                        rd_go;

    assign o_full  = (r_count == DEPTH_CNT);
    assign o_empty = (r_count == '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign wr_go   = i_wr && !o_full;
    assign rd_go   = i_rd && !o_empty;

    // Advance pointers and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_go) begin
            n_wr_ptr = (r_wr_ptr == LAST_SLOT) ? '0 : r_wr_ptr + fmcd_pkg::QPTR_W'(1);
        end
        if (rd_go) begin
            n_rd_ptr = (r_rd_ptr == LAST_SLOT) ? '0 : r_rd_ptr + fmcd_pkg::QPTR_W'(1);
        end
        if (wr_go && !rd_go) begin
            n_count = r_count + fmcd_pkg::QCNT_W'(1);
        end else if (rd_go && !wr_go) begin
            n_count = r_count - fmcd_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store incoming item
    always_ff @(posedge i_clk) begin
        if (wr_go) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    `FMCD_ASSERT_RST(a_q_bound, i_clk, i_rst_n, r_count <= DEPTH_CNT, "queue count beyond depth")
    `FMCD_ASSERT_RST(a_q_grow, i_clk, i_rst_n, (wr_go && !rd_go) |=> (r_count == $past(r_count) + fmcd_pkg::QCNT_W'(1)), "queue count did not grow on write")

endmodule

// ----- rtl/core/fmcd_back.sv -----
// Back end: executes classified items on the motion state and holds the result
`include "assert_macros.svh"

module fmcd_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_avail,
    input  fmcd_pkg::t_job                   i_job,
    output logic                             o_take,
    input  logic                             i_pop,
    output logic                             o_empty,
    output logic                             o_frame_ok,
    output logic signed [8:0]                o_distance_x,
    output logic signed [8:0]                o_distance_y,
    output logic [7:0]                       o_speed_value,
    output logic [7:0]                       o_correction_value,
    output logic                             o_one_move,
    output logic                             o_stop_pulse,
    output logic                             o_tilt_write,
    output logic                             o_tilt_enable,
    output logic                             o_recalibrate_pulse,
    output logic [fmcd_pkg::REPLY_W-1:0]     o_reply_payload
);

    logic                          r_valid;
    logic signed [8:0]             r_x, n_x;
    logic signed [8:0]             r_y, n_y;
    logic [7:0]                    r_speed, n_speed;
    logic [7:0]                    r_corr, n_corr;
    logic                          r_one_move, n_one_move;
    logic [fmcd_pkg::REPLY_W-1:0]  r_reply, n_reply;
    logic                          r_ok, r_stop, r_tw, r_te, r_recal;
    logic signed [8:0]             pos1, neg1, pos2, neg2;

    // Take the next item when the result slot is free or being emptied
    assign o_take = i_avail && (!r_valid || i_pop);

    assign pos1 = $signed({1'b0, i_job.b1});
    assign neg1 = $signed(9'd0 - {1'b0, i_job.b1});
    assign pos2 = $signed({1'b0, i_job.b2});
    assign neg2 = $signed(9'd0 - {1'b0, i_job.b2});

    // Apply command to motion state
    always_comb begin
        n_x        = r_x;
        n_y        = r_y;
        n_speed    = r_speed;
        n_corr     = r_corr;
        n_one_move = r_one_move;
        n_reply    = r_reply;
        if (i_job.ok) begin
            n_reply = i_job.reply;
        end
        case (i_job.cmd)
            fmcd_pkg::CMD_Y_POS: begin
                n_y     = pos1;
                n_speed = i_job.b2;
                n_corr  = i_job.b3;
            end
            fmcd_pkg::CMD_Y_NEG: begin
                n_y     = neg1;
                n_speed = i_job.b2;
                n_corr  = i_job.b3;
            end
            fmcd_pkg::CMD_X_NEG: begin
                n_x     = neg1;
                n_speed = i_job.b2;
                n_corr  = i_job.b3;
            end
            fmcd_pkg::CMD_MOVE_POS: begin
                n_y        = pos1;
                n_x        = pos2;
                n_one_move = 1'b1;
            end
            fmcd_pkg::CMD_MOVE_NEG: begin
                n_y        = neg1;
                n_x        = neg2;
                n_one_move = 1'b1;
            end
            default: ;
        endcase
    end

    // Motion state and result slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_x        <= '0;
            r_y        <= '0;
            r_speed    <= '0;
            r_corr     <= '0;
            r_one_move <= 1'b0;
            r_reply    <= '0;
        end else if (o_take) begin
            r_valid    <= 1'b1;
            r_x        <= n_x;
            r_y        <= n_y;
            r_speed    <= n_speed;
            r_corr     <= n_corr;
            r_one_move <= n_one_move;
            r_reply    <= n_reply;
        end else if (i_pop) begin
            r_valid    <= 1'b0;
        end
    end

    // Per-item pulses
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_ok    <= i_job.ok;
            r_stop  <= (i_job.cmd == fmcd_pkg::CMD_MOVE_POS) ||
                       (i_job.cmd == fmcd_pkg::CMD_MOVE_NEG);
            r_tw    <= (i_job.cmd == fmcd_pkg::CMD_TILT_OFF) ||
                       (i_job.cmd == fmcd_pkg::CMD_TILT_ON);
            r_te    <= (i_job.cmd == fmcd_pkg::CMD_TILT_ON);
            r_recal <= (i_job.cmd == fmcd_pkg::CMD_TILT_OFF);
        end
    end

    assign o_empty             = !r_valid;
    assign o_frame_ok          = r_ok;
    assign o_distance_x        = r_x;
    assign o_distance_y        = r_y;
    assign o_speed_value       = r_speed;
    assign o_correction_value  = r_corr;
    assign o_one_move          = r_one_move;
    assign o_stop_pulse        = r_stop;
    assign o_tilt_write        = r_tw;
    assign o_tilt_enable       = r_te;
    assign o_recalibrate_pulse = r_recal;
    assign o_reply_payload     = r_reply;

    `FMCD_ASSERT_RST(a_bk_sticky, i_clk, i_rst_n, r_one_move |=> r_one_move, "one-move flag cleared")
    `FMCD_ASSERT_RST(a_bk_stop_ok, i_clk, i_rst_n, (r_valid && r_stop) |-> r_ok, "stop without valid frame")
    `FMCD_ASSERT_RST(a_bk_recal, i_clk, i_rst_n, (r_valid && r_recal) |-> (r_tw && !r_te), "recalibrate without tilt-off write")

endmodule

// ----- rtl/core/framed_motion_command_decoder.sv -----
// Top level of the framed motion command decoder
//
//  channel   | handshake              | payload
//  ----------+------------------------+-------------------------------------------
//  byte in   | push / full            | i_rx_byte
//  result    | empty / pop            | o_frame_ok .. o_reply_payload (one per byte)
//  config    | i_cfg_we, i_cfg_idx    | i_cfg_wdata (0 header byte, 1 tail byte)
//
//  One byte is accepted per cycle unless full; its result passes the queue and the result slot.
//  The front classifies in the accept cycle; the back applies one item per cycle unless stalled.
//  A four-item queue lets the front keep taking bytes while the result slot is stalled.
//  Synchronous active-low reset clears phase, queue, motion state and config to defaults.
module framed_motion_command_decoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [7:0]                      i_rx_byte,
    output logic                            empty,
    input  logic                            pop,
    output logic                            o_frame_ok,
    output logic signed [8:0]               o_distance_x,
    output logic signed [8:0]               o_distance_y,
    output logic [7:0]                      o_speed_value,
    output logic [7:0]                      o_correction_value,
    output logic                            o_one_move,
    output logic                            o_stop_pulse,
    output logic                            o_tilt_write,
    output logic                            o_tilt_enable,
    output logic                            o_recalibrate_pulse,
    output logic [fmcd_pkg::REPLY_W-1:0]    o_reply_payload,
    input  logic                            i_cfg_we,
    input  logic [fmcd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [7:0]                      i_cfg_wdata
);

    fmcd_pkg::t_job front_job;
    fmcd_pkg::t_job head_job;
    logic           accept;
    logic           q_empty;
    logic           take;

    assign accept = push && !full;

    fmcd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_rx_byte   (i_rx_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_job       (front_job)
    );

    fmcd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept),
        .i_data  (front_job),
        .o_full  (full),
        .i_rd    (take),
        .o_data  (head_job),
        .o_empty (q_empty)
    );

    fmcd_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_avail             (!q_empty),
        .i_job               (head_job),
        .o_take              (take),
        .i_pop               (pop),
        .o_empty             (empty),
        .o_frame_ok          (o_frame_ok),
        .o_distance_x        (o_distance_x),
        .o_distance_y        (o_distance_y),
        .o_speed_value       (o_speed_value),
        .o_correction_value  (o_correction_value),
        .o_one_move          (o_one_move),
        .o_stop_pulse        (o_stop_pulse),
        .o_tilt_write        (o_tilt_write),
        .o_tilt_enable       (o_tilt_enable),
        .o_recalibrate_pulse (o_recalibrate_pulse),
        .o_reply_payload     (o_reply_payload)
    );

endmodule

// ----- verif/framed_motion_command_decoder_tb.sv -----
// Self-checking testbench for the framed motion command decoder
`timescale 1ns / 1ps

module framed_motion_command_decoder_tb;
    import fmcd_pkg::*;

    // Longest correct run stays far below this: ~2000 bytes, random gaps between bursts,
    // random receiver stall stretches, plus drains
    localparam int CYCLE_LIMIT = 400_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_BYTES = 425;

    localparam logic [7:0] OP_UNUSED_LO = 8'h00;
    localparam logic [7:0] OP_UNUSED_HI = 8'hFF;

    // One decoded result, as seen on the output ports
    typedef struct packed {
        logic                frame_ok;
        logic [8:0]          dist_x;
        logic [8:0]          dist_y;
        logic [7:0]          speed;
        logic [7:0]          correction;
        logic                one_move;
        logic                stop;
        logic                tilt_write;
        logic                tilt_enable;
        logic                recalibrate;
        logic [REPLY_W-1:0]  reply;
    } t_motion_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic [7:0]            i_rx_byte = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic                  o_frame_ok;
    logic signed [8:0]     o_distance_x;
    logic signed [8:0]     o_distance_y;
    logic [7:0]            o_speed_value;
    logic [7:0]            o_correction_value;
    logic                  o_one_move;
    logic                  o_stop_pulse;
    logic                  o_tilt_write;
    logic                  o_tilt_enable;
    logic                  o_recalibrate_pulse;
    logic [REPLY_W-1:0]    o_reply_payload;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [7:0]            i_cfg_wdata = '0;

    framed_motion_command_decoder i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .push                (push),
        .full                (full),
        .i_rx_byte           (i_rx_byte),
        .empty               (empty),
        .pop                 (pop),
        .o_frame_ok          (o_frame_ok),
        .o_distance_x        (o_distance_x),
        .o_distance_y        (o_distance_y),
        .o_speed_value       (o_speed_value),
        .o_correction_value  (o_correction_value),
        .o_one_move          (o_one_move),
        .o_stop_pulse        (o_stop_pulse),
        .o_tilt_write        (o_tilt_write),
        .o_tilt_enable       (o_tilt_enable),
        .o_recalibrate_pulse (o_recalibrate_pulse),
        .o_reply_payload     (o_reply_payload),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_wdata         (i_cfg_wdata)
    );

    // Deframer state mirrored by the predictor
    logic [7:0]         header_cfg = HEADER_RESET;
    logic [7:0]         tail_cfg = TAIL_RESET;
    t_phase             rx_phase = PH_HUNT;
    int                 rx_count = 0;
    logic [7:0]         payload_bytes [PAYLOAD_BYTES];
    logic [8:0]         x_dist = '0;
    logic [8:0]         y_dist = '0;
    logic [7:0]         speed_now = '0;
    logic [7:0]         correction_now = '0;
    logic               one_move_now = 1'b0;
    logic [REPLY_W-1:0] reply_now = '0;

    t_motion_result     pending_results [$];

    int mismatches = 0;
    int cycle_count = 0;
    int bytes_sent = 0;
    int frames_sent = 0;
    int frames_seen = 0;
    int wrong_tails = 0;
    int marker_settings = 0;
    int burst_left = 1;
    int stall_mode = 0;
    int stall_left = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("framed_motion_command_decoder_tb NOT OK");
            $finish;
        end
    end

    // Compute the result of one accepted byte and queue it
    task automatic decode_rx_byte(input logic [7:0] rx);
        t_motion_result r;
        logic [7:0]     b1;
        logic [7:0]     b2;
        logic [7:0]     b3;
        r = '0;
        b1 = payload_bytes[1];
        b2 = payload_bytes[2];
        b3 = payload_bytes[3];
        case (rx_phase)
            PH_BODY: begin
                payload_bytes[rx_count] = rx;
                if (rx_count == PAYLOAD_BYTES - 1) begin
                    rx_phase = PH_TAIL;
                    rx_count = 0;
                end else begin
                    rx_count++;
                end
            end
            PH_TAIL: begin
                // Anything but the tail is dropped while waiting for it
                if (rx == tail_cfg) begin
                    rx_phase = PH_HUNT;
                    r.frame_ok = 1'b1;
                    case (payload_bytes[0])
                        OP_Y_FWD, OP_Y_FWD_ALT: begin
                            y_dist = {1'b0, b1};
                            speed_now = b2;
                            correction_now = b3;
                        end
                        OP_Y_BACK: begin
                            y_dist = 9'd0 - {1'b0, b1};
                            speed_now = b2;
                            correction_now = b3;
                        end
                        OP_X_BACK: begin
                            x_dist = 9'd0 - {1'b0, b1};
                            speed_now = b2;
                            correction_now = b3;
                        end
                        OP_MOVE_POS: begin
                            y_dist = {1'b0, b1};
                            x_dist = {1'b0, b2};
                            one_move_now = 1'b1;
                            r.stop = 1'b1;
                        end
                        OP_MOVE_NEG: begin
                            y_dist = 9'd0 - {1'b0, b1};
                            x_dist = 9'd0 - {1'b0, b2};
                            one_move_now = 1'b1;
                            r.stop = 1'b1;
                        end
                        OP_TILT: begin
                            if (b1 == TILT_ARG_OFF) begin
                                r.tilt_write = 1'b1;
                                r.recalibrate = 1'b1;
                            end else if (b1 == TILT_ARG_ON) begin
                                r.tilt_write = 1'b1;
                                r.tilt_enable = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                    reply_now = {payload_bytes[5], payload_bytes[4], payload_bytes[3],
                                 payload_bytes[2], payload_bytes[1]};
                end
            end
            default: begin
                if (rx == header_cfg) begin
                    rx_phase = PH_BODY;
                    rx_count = 0;
                end
            end
        endcase
        r.dist_x = x_dist;
        r.dist_y = y_dist;
        r.speed = speed_now;
        r.correction = correction_now;
        r.one_move = one_move_now;
        r.reply = reply_now;
        pending_results.push_back(r);
    endtask

    // Offer one byte, hold it until taken, then maybe idle
    task automatic push_rx_byte(input logic [7:0] rx);
        int gap;
        push <= 1'b1;
        i_rx_byte <= rx;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        decode_rx_byte(rx);
        bytes_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Stop sending and wait until every result has been taken
    task automatic drain_results();
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_marker(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_HEADER) begin
            header_cfg = val;
        end else begin
            tail_cfg = val;
        end
    endtask

    task automatic set_markers(input logic [7:0] hdr, input logic [7:0] tl);
        drain_results();
        write_marker(CFG_HEADER, hdr);
        write_marker(CFG_TAIL, tl);
        marker_settings++;
    endtask

    // Send header, command, five argument bytes, optional stray bytes, tail
    task automatic send_frame(input logic [7:0] cmd, input logic [REPLY_W-1:0] args,
                              input int strays);
        logic [7:0] stray;
        push_rx_byte(header_cfg);
        push_rx_byte(cmd);
        for (int i = 0; i < REPLY_BYTES; i++) begin
            push_rx_byte(args[8*i +: 8]);
        end
        for (int i = 0; i < strays; i++) begin
            // Favor the header byte among the strays when it differs from the tail
            if (header_cfg != tail_cfg && $urandom_range(0, 2) == 0) begin
                stray = header_cfg;
            end else begin
                do stray = 8'($urandom_range(0, 255)); while (stray == tail_cfg);
            end
            push_rx_byte(stray);
            wrong_tails++;
        end
        push_rx_byte(tail_cfg);
        frames_sent++;
    endtask

    function automatic logic [7:0] pick_arg();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h01;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_command();
        case ($urandom_range(0, 9))
            0: return OP_Y_FWD;
            1: return OP_Y_FWD_ALT;
            2: return OP_Y_BACK;
            3: return OP_X_BACK;
            4: return OP_MOVE_POS;
            5: return OP_MOVE_NEG;
            6, 7: return OP_TILT;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Directed frames at reset markers: every command, extremes, stray bytes
    task automatic test_directed();
        push_rx_byte(OP_UNUSED_LO);
        push_rx_byte(tail_cfg);
        send_frame(OP_Y_FWD,     40'h00_00_FF_FF_FF, 0);
        send_frame(OP_Y_BACK,    40'hFF_FF_01_80_FF, 0);
        send_frame(OP_Y_BACK,    40'h00_00_00_00_00, 0);
        send_frame(OP_X_BACK,    40'h12_34_7F_00_01, 0);
        send_frame(OP_X_BACK,    40'h00_00_00_00_FF, 0);
        send_frame(OP_Y_FWD_ALT, 40'hA5_5A_33_44_00, 0);
        send_frame(OP_MOVE_POS,  40'h00_00_00_FF_FF, 0);
        send_frame(OP_MOVE_NEG,  40'h00_00_00_01_FF, 0);
        send_frame(OP_TILT,      {32'hDEAD_BEEF, TILT_ARG_OFF}, 0);
        send_frame(OP_TILT,      {32'h0000_0000, TILT_ARG_ON}, 0);
        send_frame(OP_TILT,      40'hFF_FF_FF_FF_02, 0);
        // Unknown command, header byte inside the payload, stray bytes before the tail
        send_frame(OP_UNUSED_LO, 40'hFF_FF_FF_FF_FF, 2);
        send_frame(OP_UNUSED_HI, 40'h01_02_03_04_05, 3);
    endtask

    // Mostly well-formed frames with random content, some noise and stray bytes
    task automatic run_random_frames(input int byte_budget);
        int         stop_at;
        logic [7:0] cmd;
        logic [7:0] noise;
        logic [REPLY_W-1:0] args;
        stop_at = bytes_sent + byte_budget;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(0, 9) == 0) begin
                // Line noise between frames, rarely a lone header
                repeat ($urandom_range(1, 3)) begin
                    noise = 8'($urandom_range(0, 255));
                    if (noise == header_cfg && $urandom_range(0, 3) != 0) begin
                        noise = ~noise;
                    end
                    push_rx_byte(noise);
                end
            end else begin
                cmd = pick_command();
                for (int i = 0; i < REPLY_BYTES; i++) begin
                    args[8*i +: 8] = pick_arg();
                end
                if (cmd == OP_TILT && $urandom_range(0, 2) != 0) begin
                    args[7:0] = $urandom_range(0, 1) ? TILT_ARG_ON : TILT_ARG_OFF;
                end
                send_frame(cmd, args, ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0);
            end
            if ($urandom_range(0, 30) == 0) begin
                drain_results();
            end
        end
    endtask

    task automatic test_marker_extremes();
        set_markers(8'h00, 8'hFF);
        run_random_frames(PHASE_BYTES);
        set_markers(8'hFF, 8'h00);
        run_random_frames(PHASE_BYTES);
    endtask

    task automatic test_shared_marker();
        set_markers(8'hA5, 8'hA5);
        run_random_frames(PHASE_BYTES);
    endtask

    task automatic test_random_markers();
        repeat (3) begin
            set_markers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            run_random_frames(PHASE_BYTES / 3);
        end
    endtask

    // Receiver: change stall behavior after each random stretch
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (stall_left <= 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(8, 64);
            end
            stall_left--;
            case (stall_mode)
                0: pop <= 1'b1;
                1: pop <= ($urandom_range(0, 1) == 1);
                2: pop <= ($urandom_range(0, 3) == 0);
                default: pop <= 1'b0;
            endcase
        end
    end

    task automatic check_field(input string name, input logic [63:0] exp_val,
                               input logic [63:0] got_val);
        if (exp_val !== got_val) begin
            $error("%s: expected %0h, got %0h", name, exp_val, got_val);
            mismatches++;
        end
    endtask

    // Compare each taken result with the oldest prediction
    always @(posedge i_clk) begin
        t_motion_result got;
        t_motion_result exp_r;
        if (i_rst_n && pop && !empty) begin
            got.frame_ok = o_frame_ok;
            got.dist_x = o_distance_x;
            got.dist_y = o_distance_y;
            got.speed = o_speed_value;
            got.correction = o_correction_value;
            got.one_move = o_one_move;
            got.stop = o_stop_pulse;
            got.tilt_write = o_tilt_write;
            got.tilt_enable = o_tilt_enable;
            got.recalibrate = o_recalibrate_pulse;
            got.reply = o_reply_payload;
            if (pending_results.size() == 0) begin
                $error("result taken with no prediction waiting");
                mismatches++;
            end else begin
                exp_r = pending_results.pop_front();
                if (exp_r.frame_ok) frames_seen++;
                check_field("frame_ok", 64'(exp_r.frame_ok), 64'(got.frame_ok));
                check_field("distance_x", 64'(exp_r.dist_x), 64'(got.dist_x));
                check_field("distance_y", 64'(exp_r.dist_y), 64'(got.dist_y));
                check_field("speed_value", 64'(exp_r.speed), 64'(got.speed));
                check_field("correction_value", 64'(exp_r.correction),
                            64'(got.correction));
                check_field("one_move", 64'(exp_r.one_move), 64'(got.one_move));
                check_field("stop_pulse", 64'(exp_r.stop), 64'(got.stop));
                check_field("tilt_write", 64'(exp_r.tilt_write), 64'(got.tilt_write));
                check_field("tilt_enable", 64'(exp_r.tilt_enable), 64'(got.tilt_enable));
                check_field("recalibrate_pulse", 64'(exp_r.recalibrate),
                            64'(got.recalibrate));
                check_field("reply_payload", 64'(exp_r.reply), 64'(got.reply));
            end
        end
    end

    initial begin
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            payload_bytes[i] = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_marker_extremes();
        test_shared_marker();
        test_random_markers();

        drain_results();
        if (pending_results.size() != 0) begin
            $error("%0d predictions never matched by a result", pending_results.size());
            mismatches++;
        end
        $display("sent %0d bytes in %0d frames (%0d stray bytes before a tail)",
                 bytes_sent, frames_sent, wrong_tails);
        $display("saw %0d completed frames over %0d marker settings, %0d mismatches",
                 frames_seen, marker_settings + 1, mismatches);
        if (mismatches == 0) begin
            $display("framed_motion_command_decoder_tb OK");
        end else begin
            $display("framed_motion_command_decoder_tb NOT OK");
        end
        $finish;
    end

endmodule

// ----- framed_motion_command_decoder.f -----
+incdir+rtl/core
rtl/core/fmcd_pkg.sv
rtl/core/fmcd_front.sv
rtl/core/fmcd_queue.sv
rtl/core/fmcd_back.sv
rtl/core/framed_motion_command_decoder.sv
verif/framed_motion_command_decoder_tb.sv
